// ===== hdl/blrf_pkg.sv =====
package blrf_pkg;

	// Column and run length widths follow from the longest line of 1024 pixels
	localparam int unsigned LINE_MAX = 1024;
	localparam int unsigned COL_W    = $clog2(LINE_MAX);
	localparam int unsigned LEN_W    = $clog2(LINE_MAX) + 1;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_MAX - 1);

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN = 1'b1;

	localparam int unsigned CFG_DATA_W = LEN_W;

	localparam logic [LEN_W-1:0] MIN_RUN_RESET = LEN_W'(50);

	typedef enum logic [1:0] {
		MODE_DROP = 2'd0,
		MODE_FILL = 2'd1,
		MODE_ENDS = 2'd2
	} mode_t;

endpackage

// ===== hdl/binary_line_run_filter_top.sv =====
// Binary line run filter. Mask pixels enter one word per clock on the input channel, each
// with a flag on the last pixel of its line, and foreground runs leave as (run_start,
// run_length, line_end) words. Mode 0 drops closed runs shorter than min_run but keeps a
// run still open at line end, mode 1 reports one run spanning the first to the last
// foreground pixel, mode 2 reports the last pixel of every run as a run of length 1; any
// other mode code acts as mode 0. Each line yields exactly one word with line_end set,
// empty (start 0, length 0) when nothing is kept on the last pixel. The block sustains one
// pixel per clock while the output is not stalled: a pixel waits in the input register,
// and the run tracking compare and subtract sit between it and the result register,
// from which the result word is shown on the output. The input side stalls only while a
// result waits in the result register and the downstream side stalls it. The column
// count saturates at 1023, so every pixel beyond that counts as lying in the last
// column. Configuration is written through cfg_valid/cfg_ready, which is always ready;
// write only while idle.
module binary_line_run_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [blrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blrf_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pixel,
	input  logic                            last_in_line,
	// run descriptor output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [blrf_pkg::COL_W-1:0]      run_start,
	output logic [blrf_pkg::LEN_W-1:0]      run_length,
	output logic                            line_end
);
	import blrf_pkg::*;

	// configuration
	mode_t             mode_q;
	logic [LEN_W-1:0]  min_run_q;

	// input register
	logic              valid_s1;
	logic              pixel_s1;
	logic              last_s1;

	// per-line run tracking state
	logic [COL_W-1:0]  column_q;
	logic              prev_q;
	logic [COL_W-1:0]  open_q;
	logic [COL_W-1:0]  first_q;
	logic [COL_W-1:0]  lastfg_q;
	logic              seen_q;

	// result register
	logic              out_valid_q;
	logic [COL_W-1:0]  run_start_q;
	logic [LEN_W-1:0]  run_length_q;
	logic              line_end_q;

	// datapath
	logic              out_free;
	logic              advance;
	logic              in_take;
	logic              run_open;
	logic              run_close;
	logic [COL_W-1:0]  open_n;
	logic [COL_W-1:0]  first_n;
	logic [COL_W-1:0]  lastfg_n;
	logic              seen_n;
	logic [LEN_W-1:0]  close_len;
	logic              have;
	logic [COL_W-1:0]  rs;
	logic [LEN_W-1:0]  rl;

	assign cfg_ready = 1'b1;

	// The result register can take a new word when empty or when its word leaves now
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign out_valid  = out_valid_q;
	assign run_start  = run_start_q;
	assign run_length = run_length_q;
	assign line_end   = line_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DROP;
			min_run_q <= MIN_RUN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q    <= mode_t'(cfg_data[1:0]);
				CFG_MIN_RUN: min_run_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Input register: hold while stalled, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pixel_s1 <= pixel;
			last_s1  <= last_in_line;
		end
	end

	// Run tracking for the pixel in the input register
	always_comb begin
		run_open  = pixel_s1 && !prev_q;
		run_close = !pixel_s1 && prev_q;
		open_n    = run_open ? column_q : open_q;
		first_n   = (pixel_s1 && !seen_q) ? column_q : first_q;
		lastfg_n  = pixel_s1 ? column_q : lastfg_q;
		seen_n    = seen_q || pixel_s1;
		// A closed run always has its last foreground pixel at or past its start
		close_len = LEN_W'({1'b0, lastfg_q} - {1'b0, open_q}) + LEN_W'(1);

		have = 1'b0;
		rs   = '0;
		rl   = '0;

		if (run_close) begin
			case (mode_q)
				MODE_FILL: ;
				MODE_ENDS: begin
					have = 1'b1;
					rs   = lastfg_q;
					rl   = LEN_W'(1);
				end
				default: begin
					if (close_len >= min_run_q) begin
						have = 1'b1;
						rs   = open_q;
						rl   = close_len;
					end
				end
			endcase
		end

		if (last_s1) begin
			case (mode_q)
				MODE_FILL: begin
					have = seen_n;
					rs   = first_n;
					rl   = LEN_W'({1'b0, lastfg_n} - {1'b0, first_n}) + LEN_W'(1);
				end
				MODE_ENDS: begin
					if (pixel_s1) begin
						have = 1'b1;
						rs   = column_q;
						rl   = LEN_W'(1);
					end
				end
				default: begin
					// keep a run still open at line end whatever its length
					if (pixel_s1) begin
						have = 1'b1;
						rs   = open_n;
						rl   = LEN_W'({1'b0, column_q} - {1'b0, open_n}) + LEN_W'(1);
					end
				end
			endcase
			// empty line marker when nothing is kept
			if (!have) begin
				rs = '0;
				rl = '0;
			end
		end
	end

	// Line state: advance per pixel, clear after the last pixel of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			prev_q   <= 1'b0;
			open_q   <= '0;
			first_q  <= '0;
			lastfg_q <= '0;
			seen_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				column_q <= '0;
				prev_q   <= 1'b0;
				open_q   <= '0;
				first_q  <= '0;
				lastfg_q <= '0;
				seen_q   <= 1'b0;
			end else begin
				if (column_q != COL_LAST) begin
					column_q <= column_q + COL_W'(1);
				end
				prev_q   <= pixel_s1;
				open_q   <= open_n;
				first_q  <= first_n;
				lastfg_q <= lastfg_n;
				seen_q   <= seen_n;
			end
		end
	end

	// Result register: load on every line end and every kept run, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && (have || last_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance) begin
			run_start_q  <= rs;
			run_length_q <= rl;
			line_end_q   <= last_s1;
		end
	end

endmodule

// ===== hdl/blrf_checker.sv =====
module blrf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [blrf_pkg::COL_W-1:0]      run_start,
	input  logic [blrf_pkg::LEN_W-1:0]      run_length,
	input  logic                            line_end
);
	import blrf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(run_start) && $stable(run_length)
			&& $stable(line_end))
		else $error("stalled result word changed");

	// input stalls only behind a blocked result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result register free");

	// only the empty line marker has zero length
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_length == '0 |-> line_end && run_start == '0)
		else $error("zero length word is not an empty line marker");

	// a kept run never reaches past the line
	a_run_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, run_start} + {1'b0, run_length})
			<= (LEN_W + 1)'(LINE_MAX))
		else $error("run extends past the longest line");

endmodule

bind binary_line_run_filter_top blrf_checker u_blrf_checker (.*);
